FILE: design/annexb_nal_unit_scanner_assert.svh
// Assertion macros for the Annex B NAL unit scanner.
// Needs no package; used by the top level only.
`ifndef ANNEXB_NAL_UNIT_SCANNER_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SCANNER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define ANNEXB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ANNEXB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");

`endif

FILE: design/annexb_pkg.sv
// Types and constants for the Annex B NAL unit scanner.
// Has no dependencies; imported by the top level.
package annexb_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       keyframe_in;
   } req_word_type;

   typedef struct packed {
      logic        record_kind;
      logic [31:0] nal_offset;
      logic [31:0] nal_size;
      logic [4:0]  nal_type;
      logic        has_idr;
      logic        has_sps;
      logic        has_pps;
      logic        has_aud;
      logic [31:0] avcc_bytes;
      logic        keyframe_out;
      logic        found_any;
      logic        last_result;
   } rsp_word_type;

   localparam logic       REC_SPAN    = 1'b0;
   localparam logic       REC_SUMMARY = 1'b1;

   localparam logic [7:0] BYTE_ZERO       = 8'h00;
   localparam logic [7:0] START_CODE_TAIL = 8'h01;
   localparam logic [1:0] ZERO_RUN_MAX    = 2'd3;

   localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
   localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
   localparam logic [4:0] NAL_TYPE_AUD = 5'd9;

   localparam int FLAG_IDR = 0;
   localparam int FLAG_SPS = 1;
   localparam int FLAG_PPS = 2;
   localparam int FLAG_AUD = 3;

   localparam logic [32:0] AVCC_PREFIX_BYTES = 33'd4;

   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;

endpackage

FILE: design/annexb_nal_unit_scanner.sv
// Annex B NAL unit scanner: start-code search, NAL span records and packet summary.
// Depends on annexb_pkg and the assertion macros in annexb_nal_unit_scanner_assert.svh.
// Result words are registered in a four-entry output queue and offered in arrival order.
// Throughput: one byte per cycle unless stalled; a last byte that closes a NAL queues two
// words, which drain one per cycle while rsp_ready is high; input stalls below two free entries.
// Reset (synchronous) clears the packet state and empties the output queue.
`include "annexb_nal_unit_scanner_assert.svh"

module annexb_nal_unit_scanner
   import annexb_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] body_ff, body_in;
   logic [POSITION_BITS-1:0] len_p1_ff, len_p1_in;
   logic [POSITION_BITS-1:0] len_m2_ff, len_m2_in;
   logic [POSITION_BITS-1:0] len_m3_ff, len_m3_in;
   logic [1:0]               zrun_ff, zrun_in;
   logic                     inside_ff, inside_in;
   logic [4:0]               type_ff, type_in;
   logic [3:0]               flags_ff, flags_in;
   logic [31:0]              avcc_ff, avcc_in;
   logic                     ovf_ff, ovf_in;
   logic                     any_ff, any_in;

   rsp_word_type             queue_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic                     accept;
   logic                     pop;
   logic                     sc_hit;
   logic                     first_body;
   logic [4:0]               type_eff;
   logic                     span_cand;
   logic [POSITION_BITS-1:0] span_size;
   logic                     emit;
   logic [33:0]              avcc_sum;
   logic                     avcc_counts;
   logic [3:0]               flags_new;
   logic [31:0]              avcc_new;
   logic                     ovf_new;
   logic                     any_new;
   rsp_word_type             span_word;
   rsp_word_type             sum_word;
   rsp_word_type             word0;
   logic                     push0;
   logic                     push1;
   logic [RSP_CNT_BITS-1:0]  push_cnt;

   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = cnt_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2);
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // Span detection and the packet totals as they stand after this byte.
   always_comb begin
      sc_hit     = (req_data.data_byte == START_CODE_TAIL) && zrun_ff[1];
      first_body = inside_ff && (len_p1_ff == POSITION_BITS'(1));
      type_eff   = first_body ? req_data.data_byte[4:0] : type_ff;
      if (sc_hit) begin
         span_cand = inside_ff;
         span_size = (zrun_ff == ZERO_RUN_MAX) ? len_m3_ff : len_m2_ff;
      end else begin
         span_cand = req_data.last_byte && inside_ff;
         span_size = len_p1_ff;
      end
      emit = accept && span_cand && (span_size != '0);

      avcc_counts = (type_eff != NAL_TYPE_SPS) && (type_eff != NAL_TYPE_PPS) &&
                    (type_eff != NAL_TYPE_AUD);
      avcc_sum    = {2'b00, avcc_ff} + 34'(span_size) + 34'(AVCC_PREFIX_BYTES);

      flags_new = flags_ff;
      avcc_new  = avcc_ff;
      ovf_new   = ovf_ff;
      any_new   = any_ff;
      if (emit) begin
         flags_new[FLAG_IDR] = flags_ff[FLAG_IDR] || (type_eff == NAL_TYPE_IDR);
         flags_new[FLAG_SPS] = flags_ff[FLAG_SPS] || (type_eff == NAL_TYPE_SPS);
         flags_new[FLAG_PPS] = flags_ff[FLAG_PPS] || (type_eff == NAL_TYPE_PPS);
         flags_new[FLAG_AUD] = flags_ff[FLAG_AUD] || (type_eff == NAL_TYPE_AUD);
         any_new = 1'b1;
         if (avcc_counts) begin
            avcc_new = avcc_sum[31:0];
            ovf_new  = ovf_ff || (avcc_sum[33:32] != 2'b00);
         end
      end
   end

   always_comb begin
      span_word              = '0;
      span_word.record_kind  = REC_SPAN;
      span_word.nal_offset   = 32'(body_ff);
      span_word.nal_size     = 32'(span_size);
      span_word.nal_type     = type_eff;

      sum_word               = '0;
      sum_word.record_kind   = REC_SUMMARY;
      sum_word.has_idr       = flags_new[FLAG_IDR];
      sum_word.has_sps       = flags_new[FLAG_SPS];
      sum_word.has_pps       = flags_new[FLAG_PPS];
      sum_word.has_aud       = flags_new[FLAG_AUD];
      sum_word.avcc_bytes    = ovf_new ? 32'd0 : avcc_new;
      sum_word.keyframe_out  = req_data.keyframe_in || flags_new[FLAG_IDR];
      sum_word.found_any     = any_new;
      sum_word.last_result   = 1'b1;

      push0    = emit || (accept && req_data.last_byte);
      push1    = emit && req_data.last_byte;
      word0    = emit ? span_word : sum_word;
      push_cnt = RSP_CNT_BITS'(push0) + RSP_CNT_BITS'(push1);
   end

   // Next packet state.
   always_comb begin
      pos_in    = pos_ff;
      body_in   = body_ff;
      len_p1_in = len_p1_ff;
      len_m2_in = len_m2_ff;
      len_m3_in = len_m3_ff;
      zrun_in   = zrun_ff;
      inside_in = inside_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      avcc_in   = avcc_ff;
      ovf_in    = ovf_ff;
      any_in    = any_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            pos_in    = '0;
            body_in   = '0;
            len_p1_in = '0;
            len_m2_in = '0;
            len_m3_in = '0;
            zrun_in   = '0;
            inside_in = 1'b0;
            type_in   = '0;
            flags_in  = '0;
            avcc_in   = '0;
            ovf_in    = 1'b0;
            any_in    = 1'b0;
         end else begin
            pos_in   = pos_ff + POSITION_BITS'(1);
            flags_in = flags_new;
            avcc_in  = avcc_new;
            ovf_in   = ovf_new;
            any_in   = any_new;
            if (first_body) begin
               type_in = req_data.data_byte[4:0];
            end
            if (req_data.data_byte == BYTE_ZERO) begin
               zrun_in = (zrun_ff == ZERO_RUN_MAX) ? ZERO_RUN_MAX : zrun_ff + 2'd1;
            end else begin
               zrun_in = '0;
            end
            if (sc_hit) begin
               inside_in = 1'b1;
               body_in   = pos_ff + POSITION_BITS'(1);
               len_p1_in = POSITION_BITS'(1);
               len_m2_in = '0 - POSITION_BITS'(2);
               len_m3_in = '0 - POSITION_BITS'(3);
            end else begin
               len_p1_in = len_p1_ff + POSITION_BITS'(1);
               len_m2_in = len_m2_ff + POSITION_BITS'(1);
               len_m3_in = len_m3_ff + POSITION_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_BITS'(push_cnt);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_BITS'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + push_cnt - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         body_ff   <= '0;
         len_p1_ff <= '0;
         len_m2_ff <= '0;
         len_m3_ff <= '0;
         zrun_ff   <= '0;
         inside_ff <= 1'b0;
         type_ff   <= '0;
         flags_ff  <= '0;
         avcc_ff   <= '0;
         ovf_ff    <= 1'b0;
         any_ff    <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         body_ff   <= body_in;
         len_p1_ff <= len_p1_in;
         len_m2_ff <= len_m2_in;
         len_m3_ff <= len_m3_in;
         zrun_ff   <= zrun_in;
         inside_ff <= inside_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         avcc_ff   <= avcc_in;
         ovf_ff    <= ovf_in;
         any_ff    <= any_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         queue_ff[wr_ptr_ff] <= word0;
      end
      if (push1) begin
         queue_ff[wr_ptr_ff + RSP_PTR_BITS'(1)] <= sum_word;
      end
   end

   `ANNEXB_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, cnt_ff <= RSP_CNT_BITS'(RSP_DEPTH))
   `ANNEXB_ASSERT_NOW(a_room_on_accept, clock, reset, accept,
                      cnt_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2))
   `ANNEXB_ASSERT_NEXT(a_clear_after_last, clock, reset, accept && req_data.last_byte,
                       !inside_ff && (pos_ff == '0) && (flags_ff == '0) && !any_ff)
   `ANNEXB_ASSERT_NEXT(a_last_makes_word, clock, reset, accept && req_data.last_byte,
                       rsp_valid)

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the Annex B NAL unit scanner: directed and random packets
// with random idling on both handshakes, checked word by word against a scanner model.
// Depends on annexb_pkg and the annexb_nal_unit_scanner top level.
`timescale 1ns / 1ps

module testbench;
   import annexb_pkg::*;

   localparam int POS_BITS           = 32;
   localparam int RANDOM_ITEMS       = 1550;
   localparam int OUTPUT_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES       = 12;
   localparam int CYCLE_LIMIT        = 600000;
   localparam int PRINT_LIMIT        = 40;
   localparam int DIRECTED_COUNT     = 29;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       keyframe_in;
      logic       typed;
      logic       want_key;
      logic       want_found;
   } directed_row_type;

   // Columns: byte, last, keyframe, summary typed in, keyframe_out, found_any.
   localparam directed_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h65, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h09, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h67, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
      '{8'h01, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}
   };

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   logic [POS_BITS-1:0] scan_pos   = '0;
   logic [POS_BITS-1:0] nal_start  = '0;
   logic [1:0]          zeros_seen = '0;
   logic                nal_open   = 1'b0;
   logic [4:0]          open_type  = '0;
   logic [3:0]          seen_types = '0;
   logic [32:0]         avcc_sum   = '0;
   logic                nal_seen   = 1'b0;

   rsp_word_type pending_words [$];
   rsp_word_type expected_word;
   logic [7:0]   packet_bytes [$];

   int  mismatch_count    = 0;
   int  spans_checked     = 0;
   int  summaries_checked = 0;
   int  bytes_sent        = 0;
   int  send_burst        = 0;
   logic output_hold      = 1'b0;

   annexb_nal_unit_scanner #(
      .POSITION_BITS(POS_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic expect_word(input rsp_word_type w);
      pending_words = {pending_words, w};
   endtask

   task automatic add_byte(input logic [7:0] b);
      packet_bytes = {packet_bytes, b};
   endtask

   task automatic close_nal(input logic [POS_BITS-1:0] offset,
                            input logic [POS_BITS-1:0] len);
      rsp_word_type w;
      logic [33:0]  sum;
      if (len != '0) begin
         w = '0;
         w.record_kind = REC_SPAN;
         w.nal_offset  = offset;
         w.nal_size    = len;
         w.nal_type    = open_type;
         if (open_type == NAL_TYPE_IDR) seen_types[FLAG_IDR] = 1'b1;
         if (open_type == NAL_TYPE_SPS) seen_types[FLAG_SPS] = 1'b1;
         if (open_type == NAL_TYPE_PPS) seen_types[FLAG_PPS] = 1'b1;
         if (open_type == NAL_TYPE_AUD) seen_types[FLAG_AUD] = 1'b1;
         if (open_type != NAL_TYPE_SPS && open_type != NAL_TYPE_PPS &&
             open_type != NAL_TYPE_AUD) begin
            sum = 34'(avcc_sum) + 34'(AVCC_PREFIX_BYTES) + 34'(len);
            avcc_sum = (sum > 34'h0_FFFF_FFFF) ? 33'h1_0000_0000 : sum[32:0];
         end
         nal_seen = 1'b1;
         expect_word(w);
      end
   endtask

   task automatic scan_byte(input req_word_type w);
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS-1:0] code_start;
      rsp_word_type        s;
      pos = scan_pos;
      if (nal_open && pos == nal_start) open_type = w.data_byte[4:0];
      if (w.data_byte == START_CODE_TAIL && zeros_seen >= 2'd2) begin
         code_start = pos - ((zeros_seen == ZERO_RUN_MAX) ? 3 : 2);
         if (nal_open) close_nal(nal_start, code_start - nal_start);
         nal_open = !w.last_byte;
         if (!w.last_byte) nal_start = pos + 1'b1;
      end else if (w.last_byte && nal_open) begin
         close_nal(nal_start, pos + 1'b1 - nal_start);
      end
      if (w.data_byte == BYTE_ZERO)
         zeros_seen = (zeros_seen == ZERO_RUN_MAX) ? ZERO_RUN_MAX : zeros_seen + 2'd1;
      else
         zeros_seen = '0;
      if (w.last_byte) begin
         s = '0;
         s.record_kind  = REC_SUMMARY;
         s.has_idr      = seen_types[FLAG_IDR];
         s.has_sps      = seen_types[FLAG_SPS];
         s.has_pps      = seen_types[FLAG_PPS];
         s.has_aud      = seen_types[FLAG_AUD];
         s.avcc_bytes   = avcc_sum[32] ? 32'd0 : avcc_sum[31:0];
         s.keyframe_out = w.keyframe_in | seen_types[FLAG_IDR];
         s.found_any    = nal_seen;
         s.last_result  = 1'b1;
         expect_word(s);
         scan_pos   = '0;
         nal_start  = '0;
         zeros_seen = '0;
         nal_open   = 1'b0;
         open_type  = '0;
         seen_types = '0;
         avcc_sum   = '0;
         nal_seen   = 1'b0;
      end else begin
         scan_pos = pos + 1'b1;
      end
   endtask

   task automatic offer_word(input req_word_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      scan_byte(w);
      bytes_sent++;
   endtask

   task automatic sender_idle();
      int gap;
      if (send_burst > 0) begin
         send_burst--;
      end else begin
         send_burst = $urandom_range(0, 24);
         gap = idle_cycles();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic build_packet();
      int mode;
      int len;
      logic [4:0] kind;
      packet_bytes.delete();
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
         repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(2, 255)));
         repeat ($urandom_range(1, 5)) begin
            repeat (($urandom_range(0, 9) < 7) ? 2 : $urandom_range(3, 5))
               add_byte(BYTE_ZERO);
            add_byte(START_CODE_TAIL);
            if ($urandom_range(0, 15) == 0) len = 0;
            else if ($urandom_range(0, 19) == 0) len = $urandom_range(40, 300);
            else len = $urandom_range(1, 12);
            if (len > 0) begin
               case ($urandom_range(0, 5))
                  0: kind = NAL_TYPE_IDR;
                  1: kind = NAL_TYPE_SPS;
                  2: kind = NAL_TYPE_PPS;
                  3: kind = NAL_TYPE_AUD;
                  4: kind = 5'd1;
                  default: kind = 5'($urandom);
               endcase
               add_byte({3'($urandom), kind});
               repeat (len - 1)
                  add_byte(($urandom_range(0, 3) == 0) ? BYTE_ZERO : 8'($urandom));
            end
         end
         case ($urandom_range(0, 9))
            0, 1: repeat ($urandom_range(1, 3)) add_byte(BYTE_ZERO);
            2: begin
               repeat ($urandom_range(2, 3)) add_byte(BYTE_ZERO);
               add_byte(START_CODE_TAIL);
            end
            default: ;
         endcase
      end else if (mode < 90) begin
         repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 3))
               0: add_byte(BYTE_ZERO);
               1: add_byte(START_CODE_TAIL);
               default: add_byte(8'($urandom));
            endcase
         end
      end else begin
         add_byte(BYTE_ZERO);
         add_byte(BYTE_ZERO);
         add_byte(START_CODE_TAIL);
         add_byte(8'($urandom));
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
               0: begin
                  add_byte(BYTE_ZERO);
                  add_byte(START_CODE_TAIL);
               end
               1: begin
                  add_byte(BYTE_ZERO);
                  add_byte(BYTE_ZERO);
                  add_byte(8'($urandom_range(2, 255)));
               end
               default: repeat (3) add_byte(BYTE_ZERO);
            endcase
         end
      end
   endtask

   initial begin : stimulus
      directed_row_type row;
      rsp_word_type     typed_word;
      req_word_type     w;
      int               random_sent;
      random_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED[i];
         w.data_byte   = row.data_byte;
         w.last_byte   = row.last_byte;
         w.keyframe_in = row.keyframe_in;
         offer_word(w);
         if (row.typed) begin
            typed_word = '0;
            typed_word.record_kind  = REC_SUMMARY;
            typed_word.keyframe_out = row.want_key;
            typed_word.found_any    = row.want_found;
            typed_word.last_result  = 1'b1;
            pending_words[pending_words.size() - 1] = typed_word;
         end
         sender_idle();
      end
      while (random_sent < RANDOM_ITEMS) begin
         build_packet();
         foreach (packet_bytes[k]) begin
            w.data_byte   = packet_bytes[k];
            w.last_byte   = (k == packet_bytes.size() - 1);
            w.keyframe_in = 1'($urandom);
            offer_word(w);
            random_sent++;
            // Stall the output long enough for the queue to fill and back up the input.
            if (random_sent == 500) output_hold = 1'b1;
            if (random_sent == 1000) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_words.size() != 0);
            end else begin
               sender_idle();
            end
         end
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d packets with random idling, a long output stall",
               bytes_sent, summaries_checked);
      $display("and a full drain; checked %0d NAL spans and %0d summaries, %0d mismatches.",
               spans_checked, summaries_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS annexb_nal_unit_scanner");
      else
         $display("FAIL annexb_nal_unit_scanner");
      $finish;
   end

   initial begin : receiver
      int gap;
      wait (reset == 1'b0);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (output_hold) begin
            gap = OUTPUT_HOLD_CYCLES;
            output_hold = 1'b0;
         end else begin
            gap = idle_cycles();
         end
         rsp_ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with nothing expected, offset", rsp_data.nal_offset, 0);
         end else begin
            expected_word = pending_words.pop_front();
            if (expected_word.record_kind == REC_SUMMARY) summaries_checked++;
            else spans_checked++;
            if (rsp_data.record_kind !== expected_word.record_kind)
               report_mismatch("record_kind", rsp_data.record_kind, expected_word.record_kind);
            if (rsp_data.nal_offset !== expected_word.nal_offset)
               report_mismatch("nal_offset", rsp_data.nal_offset, expected_word.nal_offset);
            if (rsp_data.nal_size !== expected_word.nal_size)
               report_mismatch("nal_size", rsp_data.nal_size, expected_word.nal_size);
            if (rsp_data.nal_type !== expected_word.nal_type)
               report_mismatch("nal_type", rsp_data.nal_type, expected_word.nal_type);
            if (rsp_data.has_idr !== expected_word.has_idr)
               report_mismatch("has_idr", rsp_data.has_idr, expected_word.has_idr);
            if (rsp_data.has_sps !== expected_word.has_sps)
               report_mismatch("has_sps", rsp_data.has_sps, expected_word.has_sps);
            if (rsp_data.has_pps !== expected_word.has_pps)
               report_mismatch("has_pps", rsp_data.has_pps, expected_word.has_pps);
            if (rsp_data.has_aud !== expected_word.has_aud)
               report_mismatch("has_aud", rsp_data.has_aud, expected_word.has_aud);
            if (rsp_data.avcc_bytes !== expected_word.avcc_bytes)
               report_mismatch("avcc_bytes", rsp_data.avcc_bytes, expected_word.avcc_bytes);
            if (rsp_data.keyframe_out !== expected_word.keyframe_out)
               report_mismatch("keyframe_out", rsp_data.keyframe_out,
                               expected_word.keyframe_out);
            if (rsp_data.found_any !== expected_word.found_any)
               report_mismatch("found_any", rsp_data.found_any, expected_word.found_any);
            if (rsp_data.last_result !== expected_word.last_result)
               report_mismatch("last_result", rsp_data.last_result, expected_word.last_result);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL annexb_nal_unit_scanner");
      $finish;
   end

endmodule
